@@ sv/assert_macros.svh @@
// Assertion macros, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

@@ sv/asp_pkg.sv @@
package asp_pkg;

    // pool geometry
    localparam int SLOTS      = 64;
    localparam int COORD_BITS = 16;
    localparam int DECAY_BITS = 16;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // fixed field widths on the ports
    localparam int MODE_W  = 2;
    localparam int POS_W   = 16;
    localparam int DEC_W   = 16;
    localparam int IDX_W   = 6;
    localparam int CNTF_W  = 7;

    // input tdata layout, lowest field first
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + POS_W;
    localparam int D_LSB      = Y_LSB + POS_W;
    localparam int I_LSB      = D_LSB + DEC_W;
    localparam int IN_FIELD_W = I_LSB + IDX_W;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_FIELD_W = IDX_W + 2 + DEC_W + 2 * POS_W + 2 * CNTF_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // front queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // mode codes on tuser
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_TICK,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [DECAY_BITS-1:0]  decay;
        logic [IDX_W-1:0]       idx;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  slot;
        logic              full;
        logic              live;
        logic [DEC_W-1:0]  decay;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CNTF_W-1:0] used;
        logic [CNTF_W-1:0] free;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_TICK_END,
        ST_READ,
        ST_NOP
    } state_t;

    function automatic logic [COORD_BITS-1:0] coord_in(input logic signed [POS_W-1:0] v);
        return COORD_BITS'(v);
    endfunction

    function automatic logic [POS_W-1:0] coord_out(input logic signed [COORD_BITS-1:0] v);
        return POS_W'(v);
    endfunction

endpackage

@@ sv/asp_front.sv @@
module asp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [asp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [asp_pkg::MODE_W-1:0]     s_tuser,
    output asp_pkg::cmd_t                  cmd,
    output logic                           cmd_valid,
    input  logic                           cmd_pop
);
    import asp_pkg::*;

    cmd_t              q_mem [QDEPTH];
    cmd_t              cmd_in;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    // classify and convert
    always_comb
    begin
        cmd_in.x     = coord_in(s_tdata[X_LSB +: POS_W]);
        cmd_in.y     = coord_in(s_tdata[Y_LSB +: POS_W]);
        cmd_in.decay = DECAY_BITS'(s_tdata[D_LSB +: DEC_W]);
        cmd_in.idx   = s_tdata[I_LSB +: IDX_W];
        case (s_tuser)
            MODE_ADD:  cmd_in.kind = CMD_ADD;
            MODE_TICK: cmd_in.kind = CMD_TICK;
            MODE_READ: cmd_in.kind = CMD_READ;
            default:   cmd_in.kind = CMD_NOP;
        endcase
    end

    assign s_tready  = (count_reg != QCNT_W'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ sv/asp_back.sv @@
module asp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  asp_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    output asp_pkg::res_t res,
    output logic          res_valid,
    input  logic          res_ready
);
    import asp_pkg::*;

    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // slot stores and free list
    logic [DECAY_BITS-1:0] decay_mem [SLOTS];
    logic [COORD_BITS-1:0] x_mem     [SLOTS];
    logic [COORD_BITS-1:0] y_mem     [SLOTS];
    logic [SLOT_W-1:0]     fifo_mem  [SLOTS];

    logic [DECAY_BITS-1:0] decay_q;
    logic [COORD_BITS-1:0] x_q, y_q;
    logic [SLOT_W-1:0]     fifo_q;

    logic                  dec_re, dec_we, xy_we, fifo_re, fifo_we;
    logic [SLOT_W-1:0]     dec_raddr, dec_waddr, fifo_waddr, fifo_wdata;
    logic [DECAY_BITS-1:0] dec_wdata;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic              d_vld_reg, d_vld_next;
    logic [SLOT_W-1:0] d_idx_reg, d_idx_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]  ucnt_reg, ucnt_next;
    res_t              res_reg, res_next;
    logic              res_vld_reg, res_vld_next;

    logic              out_free;
    logic [SUM_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] tail_idx, head_inc, add_slot;
    logic              in_range;

    assign out_free = !res_vld_reg || res_ready;
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fcnt_reg);
    assign tail_idx = (tail_sum >= SUM_W'(SLOTS)) ? SLOT_W'(tail_sum - SUM_W'(SLOTS))
                                                  : SLOT_W'(tail_sum);
    assign head_inc = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign add_slot = (fcnt_reg != '0) ? fifo_q : ucnt_reg[SLOT_W-1:0];
    assign in_range = CMP_W'(cmd_reg.idx) < CMP_W'(ucnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        i_next       = i_reg;
        d_vld_next   = d_vld_reg;
        d_idx_next   = d_idx_reg;
        head_next    = head_reg;
        fcnt_next    = fcnt_reg;
        ucnt_next    = ucnt_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg && !res_ready;
        cmd_pop      = 1'b0;
        dec_re       = 1'b0;
        dec_raddr    = SLOT_W'(cmd.idx);
        dec_we       = 1'b0;
        dec_waddr    = d_idx_reg;
        dec_wdata    = decay_q - DECAY_BITS'(1);
        xy_we        = 1'b0;
        fifo_re      = 1'b0;
        fifo_we      = 1'b0;
        fifo_waddr   = tail_idx;
        fifo_wdata   = d_idx_reg;

        // tick write-back: decrement, push slots that just expired
        if (d_vld_reg && decay_q != '0)
        begin
            dec_we = 1'b1;
            if (decay_q == DECAY_BITS'(1) && fcnt_reg < CNT_W'(SLOTS))
            begin
                fifo_we   = 1'b1;
                fcnt_next = fcnt_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.kind)
                        CMD_ADD:
                        begin
                            fifo_re    = 1'b1;
                            state_next = ST_ADD;
                        end
                        CMD_TICK:
                        begin
                            i_next     = '0;
                            state_next = ST_TICK;
                        end
                        CMD_READ:
                        begin
                            dec_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_NOP;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    res_next = '0;
                    if (fcnt_reg != '0)
                    begin
                        head_next = head_inc;
                        fcnt_next = fcnt_reg - 1'b1;
                    end
                    else if (ucnt_reg < CNT_W'(SLOTS))
                    begin
                        ucnt_next = ucnt_reg + 1'b1;
                    end
                    if (fcnt_reg != '0 || ucnt_reg < CNT_W'(SLOTS))
                    begin
                        dec_we        = 1'b1;
                        xy_we         = 1'b1;
                        dec_waddr     = add_slot;
                        dec_wdata     = cmd_reg.decay;
                        res_next.slot = IDX_W'(add_slot);
                    end
                    else
                    begin
                        res_next.full = 1'b1;
                    end
                    res_next.used = CNTF_W'(ucnt_next);
                    res_next.free = CNTF_W'(fcnt_next);
                    res_vld_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (i_reg < ucnt_reg)
                begin
                    dec_re     = 1'b1;
                    dec_raddr  = i_reg[SLOT_W-1:0];
                    d_vld_next = 1'b1;
                    d_idx_next = i_reg[SLOT_W-1:0];
                    i_next     = i_reg + 1'b1;
                end
                else
                begin
                    d_vld_next = 1'b0;
                    state_next = ST_TICK_END;
                end
            end
            ST_TICK_END:
            begin
                if (out_free)
                begin
                    if (fcnt_reg == ucnt_reg)
                    begin
                        fcnt_next = '0;
                        ucnt_next = '0;
                        head_next = '0;
                    end
                    res_next      = '0;
                    res_next.used = CNTF_W'(ucnt_next);
                    res_next.free = CNTF_W'(fcnt_next);
                    res_vld_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    res_next      = '0;
                    res_next.slot = cmd_reg.idx;
                    if (in_range)
                    begin
                        res_next.live  = (decay_q != '0);
                        res_next.decay = DEC_W'(decay_q);
                        res_next.x     = coord_out(x_q);
                        res_next.y     = coord_out(y_q);
                    end
                    res_next.used = CNTF_W'(ucnt_reg);
                    res_next.free = CNTF_W'(fcnt_reg);
                    res_vld_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_NOP:
            begin
                if (out_free)
                begin
                    res_next      = '0;
                    res_next.used = CNTF_W'(ucnt_reg);
                    res_next.free = CNTF_W'(fcnt_reg);
                    res_vld_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            d_vld_reg   <= 1'b0;
            head_reg    <= '0;
            fcnt_reg    <= '0;
            ucnt_reg    <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            d_vld_reg   <= d_vld_next;
            head_reg    <= head_next;
            fcnt_reg    <= fcnt_next;
            ucnt_reg    <= ucnt_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        d_idx_reg <= d_idx_next;
        res_reg   <= res_next;
    end

    // stores: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (dec_we)
        begin
            decay_mem[dec_waddr] <= dec_wdata;
        end
        if (xy_we)
        begin
            x_mem[dec_waddr] <= cmd_reg.x;
            y_mem[dec_waddr] <= cmd_reg.y;
        end
        if (dec_re)
        begin
            decay_q <= decay_mem[dec_raddr];
            x_q     <= x_mem[dec_raddr];
            y_q     <= y_mem[dec_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (fifo_re)
        begin
            fifo_q <= fifo_mem[head_reg];
        end
    end

    assign res       = res_reg;
    assign res_valid = res_vld_reg;

endmodule

@@ sv/aging_slot_pool.sv @@
// Channel  Dir  tdata (low bit first)                          tuser
// s_*      in   pos_x, pos_y, decay_start, read_index, pad      mode
// m_*      out  slot, full_res, entry_live, entry_decay,        -
//               entry_x, entry_y, used_slots, free_slots, pad
//
// The sequencer in asp_back takes a new item only from idle: add, read and unused
// mode each go through their own state, which waits for the output register to be free;
// a tick walks the used slots (one decay read per cycle, write-back in the next cycle).
// Reset: asynchronous, rst_n low; counts and pointers clear, stores are not swept.
// Stalls: a two-item queue sits in front of the sequencer and the result sits
// in an output register, so input is taken while a result waits on m_tready.
`include "assert_macros.svh"

module aging_slot_pool (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x[15:0], pos_y[31:16], decay_start[47:32], read_index[53:48], pad
    input  logic [asp_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [asp_pkg::MODE_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot[5:0], full_res[6], entry_live[7], entry_decay[23:8], entry_x[39:24],
    // entry_y[55:40], used_slots[62:56], free_slots[69:63], pad
    output logic [asp_pkg::OUT_DATA_W-1:0] m_tdata
);
    import asp_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res;

    // front: classify each item and queue it
    asp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // back: slot stores, free list and the tick walk
    asp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    assign m_tdata = {OUT_PAD_W'(0), res.free, res.used, res.y, res.x,
                      res.decay, res.live, res.full, res.slot};

    // free list can never hold more slots than are allocated
    `ASSERT_IMPLY(a_free_le_used, m_tvalid, res.free <= res.used, "free count above used count")
    // a dropped add only happens with a full pool and an empty free list
    `ASSERT_IMPLY(a_full_pool, m_tvalid && res.full, res.used == CNTF_W'(SLOTS) && res.free == '0 && res.slot == '0, "add dropped while pool not full")
    // a live entry must lie inside the used region and carry a nonzero count
    `ASSERT_IMPLY(a_live_in_range, m_tvalid && res.live, CNTF_W'(res.slot) < res.used && res.decay != '0, "live entry outside used region")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import asp_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE      = 100;    // longer than the longest tick
    localparam int OPEN_ROWS   = 19;
    localparam int PIN_ROWS    = 6;
    localparam int EXP_DEPTH   = 64;     // far above the items the DUT can hold

    typedef enum int {
        TR_FILL,
        TR_CHURN,
        TR_DRAIN
    } traffic_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_CHOKE,
        RX_TOGGLE
    } rx_style_t;

    typedef struct packed {
        cmd_t item;
        logic typed;
        res_t want;
    } stim_row_t;

    localparam res_t FROM_SHADOW = '0;

    // Opening rows start from reset. Pinned-slot rows start from an empty pool and
    // run after the first traffic stage, since a slot that never reaches zero
    // keeps the pool from ever clearing again.
    localparam stim_row_t STIM_TAB [OPEN_ROWS + PIN_ROWS] = '{
        '{'{CMD_READ, 0, 0, 0, 0},                  1, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{CMD_TICK, 0, 0, 0, 0},                  1, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{CMD_NOP, 'h7fff, 'h8000, 'hffff, 'h3f}, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{CMD_ADD, 'h8000, 'h7fff, 1, 'h3f},      1, '{0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{CMD_ADD, 'h7fff, 'h8000, 2, 0},         1, '{1, 0, 0, 0, 0, 0, 2, 0}},
        '{'{CMD_READ, 0, 0, 0, 0},                  1, '{0, 0, 1, 1, 'h8000, 'h7fff, 2, 0}},
        '{'{CMD_READ, 0, 0, 0, 1},                  1, '{1, 0, 1, 2, 'h7fff, 'h8000, 2, 0}},
        // beyond the used region: only the index and the counts come back
        '{'{CMD_READ, 0, 0, 0, 'h3f},               1, '{63, 0, 0, 0, 0, 0, 2, 0}},
        '{'{CMD_NOP, 0, 0, 0, 0},                   1, '{0, 0, 0, 0, 0, 0, 2, 0}},
        '{'{CMD_TICK, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_READ, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_ADD, 0, 'hffff, 3, 0},              0, FROM_SHADOW},
        '{'{CMD_TICK, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_ADD, 'h1234, 'hedcb, 1, 0},         0, FROM_SHADOW},
        '{'{CMD_TICK, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_TICK, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_READ, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_ADD, 'h5555, 'haaaa, 1, 0},         0, FROM_SHADOW},
        '{'{CMD_TICK, 0, 0, 0, 0},                  0, FROM_SHADOW},
        '{'{CMD_ADD, 'h8000, 'h8000, 'hffff, 0},    1, '{0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{CMD_ADD, 'h7fff, 'h7fff, 0, 0},         1, '{1, 0, 0, 0, 0, 0, 2, 0}},
        // decay-zero slot is neither decremented nor freed
        '{'{CMD_TICK, 0, 0, 0, 0},                  1, '{0, 0, 0, 0, 0, 0, 2, 0}},
        '{'{CMD_READ, 0, 0, 0, 0},                  1, '{0, 0, 1, 'hfffe, 'h8000, 'h8000, 2, 0}},
        '{'{CMD_READ, 0, 0, 0, 1},                  1, '{1, 0, 0, 0, 'h7fff, 'h7fff, 2, 0}},
        '{'{CMD_READ, 0, 0, 0, 2},                  1, '{2, 0, 0, 0, 0, 0, 2, 0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow of the pool
    logic [DECAY_BITS-1:0] sh_decay [SLOTS];
    logic [COORD_BITS-1:0] sh_x     [SLOTS];
    logic [COORD_BITS-1:0] sh_y     [SLOTS];
    int unsigned           sh_ring  [SLOTS];
    int unsigned           sh_head;
    int unsigned           sh_free;
    int unsigned           sh_used;

    // expected results in order of acceptance
    res_t        exp_ring [EXP_DEPTH];
    int unsigned exp_wr;
    int unsigned exp_rd;
    int unsigned err_cnt;
    int unsigned cycles;
    int unsigned burst_left;

    aging_slot_pool i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** aging_slot_pool: FAILED **");
            $finish;
        end
    end

    // Result of one item on the shadow pool; updates the shadow.
    function automatic res_t next_pool_result(cmd_t c);
        res_t        r;
        int unsigned s;
        int unsigned i;
        bit          ok;
        r  = '0;
        ok = 1'b1;
        s  = 0;
        case (c.kind)
            CMD_ADD:
            begin
                if (sh_free > 0)
                begin
                    s       = sh_ring[sh_head];
                    sh_head = (sh_head + 1) % SLOTS;
                    sh_free--;
                end
                else if (sh_used < SLOTS)
                begin
                    s = sh_used;
                    sh_used++;
                end
                else
                begin
                    ok     = 1'b0;
                    r.full = 1'b1;
                end
                if (ok)
                begin
                    sh_decay[s] = c.decay;
                    sh_x[s]     = c.x;
                    sh_y[s]     = c.y;
                    r.slot      = IDX_W'(s);
                end
            end
            CMD_TICK:
            begin
                for (i = 0; i < sh_used; i++)
                begin
                    if (sh_decay[i] != 0)
                    begin
                        sh_decay[i] = sh_decay[i] - 1'b1;
                        if (sh_decay[i] == 0 && sh_free < SLOTS)
                        begin
                            sh_ring[(sh_head + sh_free) % SLOTS] = i;
                            sh_free++;
                        end
                    end
                end
                if (sh_free == sh_used)
                begin
                    sh_free = 0;
                    sh_used = 0;
                    sh_head = 0;
                end
            end
            CMD_READ:
            begin
                r.slot = c.idx;
                if (c.idx < sh_used)
                begin
                    r.decay = sh_decay[c.idx];
                    r.live  = (sh_decay[c.idx] != 0);
                    r.x     = sh_x[c.idx];
                    r.y     = sh_y[c.idx];
                end
            end
            default: ;
        endcase
        r.used = CNTF_W'(sh_used);
        r.free = CNTF_W'(sh_free);
        return r;
    endfunction

    function automatic res_t unpack_result(logic [OUT_DATA_W-1:0] d);
        res_t r;
        r.slot  = d[5:0];
        r.full  = d[6];
        r.live  = d[7];
        r.decay = d[23:8];
        r.x     = d[39:24];
        r.y     = d[55:40];
        r.used  = d[62:56];
        r.free  = d[69:63];
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // pin_ok lets in decays that hold a slot for good (zero, or very long)
    function automatic cmd_t random_item(traffic_t prof, bit pin_ok);
        cmd_t        c;
        int unsigned p;
        c.x = rand_coord();
        c.y = rand_coord();
        if ($urandom_range(0, 3) != 0 && sh_used > 0)
            c.idx = IDX_W'($urandom_range(0, sh_used - 1));
        else
            c.idx = IDX_W'($urandom_range(0, SLOTS - 1));

        p = $urandom_range(0, 99);
        if (pin_ok && p < 3)
            c.decay = '0;
        else if (pin_ok && p < 6)
            c.decay = '1;
        else if (pin_ok && p < 16)
            c.decay = DECAY_BITS'($urandom);
        else if (prof == TR_FILL)
            c.decay = DECAY_BITS'($urandom_range(8, 40));
        else
            c.decay = DECAY_BITS'($urandom_range(1, 6));

        p = $urandom_range(0, 99);
        case (prof)
            TR_FILL:  c.kind = p < 88 ? CMD_ADD : p < 93 ? CMD_TICK : p < 98 ? CMD_READ : CMD_NOP;
            TR_CHURN: c.kind = p < 45 ? CMD_ADD : p < 75 ? CMD_TICK : p < 95 ? CMD_READ : CMD_NOP;
            default:  c.kind = p < 12 ? CMD_ADD : p < 70 ? CMD_TICK : p < 97 ? CMD_READ : CMD_NOP;
        endcase
        return c;
    endfunction

    task automatic idle_sender(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            s_tuser  <= MODE_W'($urandom);
        end
    endtask

    // bursts of random length; now and then a long stretch with no gaps
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
        burst_left--;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    task automatic send_item(cmd_t c, bit typed, res_t want);
        res_t shadow;
        pace_sender();
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({c.idx, c.decay, c.y, c.x});
        s_tuser  <= c.kind;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        shadow = next_pool_result(c);
        exp_ring[exp_wr % EXP_DEPTH] = typed ? want : shadow;
        exp_wr++;
    endtask

    task automatic run_table(int unsigned first, int unsigned last);
        int unsigned r;
        for (r = first; r <= last; r++)
            send_item(STIM_TAB[r].item, STIM_TAB[r].typed, STIM_TAB[r].want);
    endtask

    task automatic run_traffic(int unsigned n_items, bit pin_ok, bit fill_first);
        int unsigned done;
        int unsigned seg_len;
        int unsigned k;
        traffic_t    prof;
        done = 0;
        while (done < n_items)
        begin
            if (fill_first)
            begin
                // long enough to fill the pool and drop a few adds
                prof    = TR_FILL;
                seg_len = 90;
            end
            else
            begin
                prof    = traffic_t'($urandom_range(0, 2));
                seg_len = $urandom_range(20, 70);
            end
            fill_first = 1'b0;
            for (k = 0; k < seg_len && done < n_items; k++)
            begin
                send_item(random_item(prof, pin_ok), 1'b0, FROM_SHADOW);
                done++;
            end
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
        end
    endtask

    // receiver: own stall pattern, restyled after a random stretch
    always @(negedge clk)
    begin : rx_stall
        rx_style_t   style;
        int unsigned left;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (left == 0)
            begin
                style = rx_style_t'($urandom_range(0, 3));
                left  = $urandom_range(10, 60);
            end
            left--;
            case (style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                RX_CHOKE:  m_tready <= ($urandom_range(0, 4) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got = unpack_result(m_tdata);
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected item, expected none, got %h", $time, m_tdata);
                err_cnt++;
            end
            else
            begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("slot",        16'(want.slot),  16'(got.slot));
                check_field("full_res",    16'(want.full),  16'(got.full));
                check_field("entry_live",  16'(want.live),  16'(got.live));
                check_field("entry_decay", want.decay,      got.decay);
                check_field("entry_x",     want.x,          got.x);
                check_field("entry_y",     want.y,          got.y);
                check_field("used_slots",  16'(want.used),  16'(got.used));
                check_field("free_slots",  16'(want.free),  16'(got.free));
            end
        end
    end

    initial
    begin
        int unsigned guard;
        cmd_t        tick;
        err_cnt    = 0;
        cycles     = 0;
        burst_left = 0;
        exp_wr     = 0;
        exp_rd     = 0;
        sh_head    = 0;
        sh_free    = 0;
        sh_used    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_table(0, OPEN_ROWS - 1);
        run_traffic(600, 1'b0, 1'b1);

        // empty the pool so the pinned-slot rows start from a known state
        hold_until_drained();
        tick  = '0;
        tick.kind = CMD_TICK;
        guard = 0;
        while (sh_used != 0 && guard < 300)
        begin
            send_item(tick, 1'b0, FROM_SHADOW);
            guard++;
        end
        run_table(OPEN_ROWS, OPEN_ROWS + PIN_ROWS - 1);
        run_traffic(250, 1'b1, 1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (err_cnt == 0)
            $display("** aging_slot_pool: PASSED **");
        else
            $display("** aging_slot_pool: FAILED **");
        $finish;
    end

endmodule
